// File: src/mgprm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgprm_pkg
// Shared constants, state encoding and control structs for the microphone
// gain, peak and rms level meter.
// ----------------------------------------------------------------------------
package mgprm_pkg;

	// field widths
	localparam int SLOT_W  = 32;
	localparam int GAIN_W  = 16;
	localparam int PCM_W   = 16;
	localparam int SMP_W   = 18;
	localparam int PROD_W  = 35;
	localparam int SQ_W    = 32;
	localparam int SUM_W   = 47;
	localparam int CNT_W   = 17;
	localparam int MEAN_W  = 32;
	localparam int STEP_W  = 6;

	// arithmetic constants
	localparam int RAW_SHIFT = 14;
	localparam int FRAC_W    = 10;
	localparam int GAIN_RST  = 1024;
	localparam int GAIN_MIN  = 102;
	localparam int GAIN_MAX  = 32768;
	localparam int PCM_POS   = 32767;
	localparam int PCM_NEG   = 32768;
	localparam int BLOCK_MAX = 65536;

	// iteration counts of the shared divide and root steps
	localparam int DIV_STEPS  = SUM_W;
	localparam int SQRT_STEPS = MEAN_W / 2;

	// controller states
	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_MUL  = 8'b0000_0010,
		ST_SAT  = 8'b0000_0100,
		ST_SQR  = 8'b0000_1000,
		ST_ACC  = 8'b0001_0000,
		ST_DIV  = 8'b0010_0000,
		ST_SQRT = 8'b0100_0000,
		ST_DONE = 8'b1000_0000
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic ld_in;
		logic mul;
		logic sat;
		logic sqr;
		logic acc;
		logic div_step;
		logic sqrt_step;
		logic ld_out;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic last;
		logic out_free;
	} sts_t;

endpackage

// File: src/mgprm_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgprm channel interfaces
// Valid/ready channels for the sample input, the result output and the
// gain register write port.
// ----------------------------------------------------------------------------

// sample input channel
interface mgprm_in_if import mgprm_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [SLOT_W-1:0] raw_slot;
	logic                     last_in_block;

	modport source (output valid, raw_slot, last_in_block, input ready);
	modport sink   (input valid, raw_slot, last_in_block, output ready);
endinterface

// result output channel
interface mgprm_out_if import mgprm_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [PCM_W-1:0] pcm_sample;
	logic                    levels_valid;
	logic        [PCM_W-1:0] peak_level;
	logic        [PCM_W-1:0] rms_level;

	modport source (output valid, pcm_sample, levels_valid, peak_level, rms_level,
		input ready);
	modport sink   (input valid, pcm_sample, levels_valid, peak_level, rms_level,
		output ready);
endinterface

// gain register write channel
interface mgprm_cfg_if import mgprm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [GAIN_W-1:0] gain_q10;

	modport source (output valid, gain_q10, input ready);
	modport sink   (input valid, gain_q10, output ready);
endinterface

// File: src/mgprm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgprm_ctrl
// Sequencer for the level meter: steps one request through multiply,
// saturate, square and accumulate, then runs the divide and root iterations
// on the last sample of a block.
// ----------------------------------------------------------------------------
module mgprm_ctrl import mgprm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output cmd_t cmd,
	input  sts_t sts
);

	state_t              state_q, state_d;
	logic   [STEP_W-1:0] step_q, step_d;

	// next state and command decode
	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.ld_in = 1'b1;
					state_d   = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_SAT;
			end
			ST_SAT: begin
				cmd.sat = 1'b1;
				state_d = ST_SQR;
			end
			ST_SQR: begin
				cmd.sqr = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				step_d  = '0;
				state_d = sts.last ? ST_DIV : ST_DONE;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					step_d  = '0;
					state_d = ST_SQRT;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (step_q == STEP_W'(SQRT_STEPS - 1)) begin
					step_d  = '0;
					state_d = ST_DONE;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.ld_out = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
				step_d  = '0;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	// a result load always hands control back for the next request
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_out |=> state_q == ST_IDLE)
		else $error("controller did not return to idle after result load");

	// a plain sample never enters the divide loop
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACC && !sts.last) |=> state_q == ST_DONE)
		else $error("non-final sample entered the level computation");

	// the root phase always follows a complete divide
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_SQRT) |-> $past(step_q) == STEP_W'(DIV_STEPS - 1))
		else $error("root phase started before divide finished");

endmodule

// File: src/mgprm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgprm_dp
// Datapath of the level meter: gain register, gain multiply, truncation and
// saturation, square, block accumulators, a restoring divider for the mean
// and a bit-pair square root, plus the output register.
// ----------------------------------------------------------------------------
module mgprm_dp import mgprm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	output sts_t                     sts,
	input  logic                     cfg_we,
	input  logic        [GAIN_W-1:0] cfg_gain,
	input  logic signed [SLOT_W-1:0] raw_slot,
	input  logic                     last_in,
	input  logic                     out_ready,
	output logic                     out_valid,
	output logic signed [PCM_W-1:0]  out_pcm,
	output logic                     out_levels_valid,
	output logic        [PCM_W-1:0]  out_peak,
	output logic        [PCM_W-1:0]  out_rms
);

	logic        [GAIN_W-1:0] gain_q;
	logic        [GAIN_W-1:0] gain_c;
	logic signed [SMP_W-1:0]  s18_q;
	logic        [GAIN_W-1:0] gcl_q;
	logic                     last_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [PCM_W-1:0]  pcm_q;
	logic        [PCM_W-1:0]  apcm_q;
	logic        [SQ_W-1:0]   sq_q;
	logic        [SUM_W-1:0]  sum_q;
	logic        [PCM_W-1:0]  peak_q;
	logic        [CNT_W-1:0]  count_q;
	logic        [SUM_W-1:0]  quot_q;
	logic        [CNT_W-1:0]  drem_q;
	logic        [PCM_W-1:0]  root_q;
	logic        [CNT_W-1:0]  srem_q;
	logic                     out_valid_q;

	logic                     prod_neg;
	logic        [PROD_W-1:0] prod_abs;
	logic        [PROD_W-FRAC_W-1:0] mag;
	logic        [PCM_W-1:0]  apcm_c;
	logic                     blk_open;
	logic        [SUM_W-1:0]  sum_nxt;
	logic        [CNT_W:0]    rem_sh;
	logic                     div_ge;
	logic        [CNT_W+1:0]  s_in;
	logic        [CNT_W+1:0]  trial;
	logic                     sqrt_ge;

	// gain register, keeps the written bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_W'(GAIN_RST);
		end else if (cfg_we) begin
			gain_q <= cfg_gain;
		end
	end

	// gain limited to its legal range
	always_comb begin
		if (gain_q < GAIN_W'(GAIN_MIN)) begin
			gain_c = GAIN_W'(GAIN_MIN);
		end else if (gain_q > GAIN_W'(GAIN_MAX)) begin
			gain_c = GAIN_W'(GAIN_MAX);
		end else begin
			gain_c = gain_q;
		end
	end

	// magnitude after dropping the fraction, then saturation
	always_comb begin
		prod_neg = prod_q[PROD_W-1];
		prod_abs = prod_neg ? PROD_W'(-prod_q) : PROD_W'(prod_q);
		mag      = prod_abs[PROD_W-1:FRAC_W];
		if (prod_neg) begin
			apcm_c = (mag > (PROD_W-FRAC_W)'(PCM_NEG)) ? PCM_W'(PCM_NEG) : mag[PCM_W-1:0];
		end else begin
			apcm_c = (mag > (PROD_W-FRAC_W)'(PCM_POS)) ? PCM_W'(PCM_POS) : mag[PCM_W-1:0];
		end
	end

	// block accumulation, closed once the block is full
	always_comb begin
		blk_open = count_q < CNT_W'(BLOCK_MAX);
		sum_nxt  = blk_open ? (sum_q + SUM_W'(sq_q)) : sum_q;
	end

	// restoring divide step and bit-pair root step
	always_comb begin
		rem_sh  = {drem_q, quot_q[SUM_W-1]};
		div_ge  = rem_sh >= {1'b0, count_q};
		s_in    = {srem_q, quot_q[MEAN_W-1:MEAN_W-2]};
		trial   = (CNT_W+2)'({root_q, 2'b01});
		sqrt_ge = s_in >= trial;
	end

	// sample pipeline registers
	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			s18_q  <= raw_slot[SLOT_W-1:RAW_SHIFT];
			gcl_q  <= gain_c;
			last_q <= last_in;
		end
		if (cmd.mul) begin
			prod_q <= s18_q * $signed({1'b0, gcl_q});
		end
		if (cmd.sat) begin
			apcm_q <= apcm_c;
			pcm_q  <= prod_neg ? PCM_W'(-apcm_c) : apcm_c;
		end
		if (cmd.sqr) begin
			sq_q <= apcm_q * apcm_q;
		end
	end

	// block accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			peak_q  <= '0;
			count_q <= '0;
		end else if (cmd.acc) begin
			sum_q <= sum_nxt;
			if (blk_open) begin
				if (apcm_q > peak_q) begin
					peak_q <= apcm_q;
				end
				count_q <= count_q + 1'b1;
			end
		end else if (cmd.ld_out && last_q) begin
			sum_q   <= '0;
			peak_q  <= '0;
			count_q <= '0;
		end
	end

	// mean by division, then root of the mean, sharing the quotient shifter
	// (the mean never exceeds the largest square, so it fits the low word)
	always_ff @(posedge clk) begin
		if (cmd.acc) begin
			quot_q <= sum_nxt;
			drem_q <= '0;
			root_q <= '0;
			srem_q <= '0;
		end else if (cmd.div_step) begin
			quot_q <= {quot_q[SUM_W-2:0], div_ge};
			drem_q <= div_ge ? CNT_W'(rem_sh - {1'b0, count_q}) : rem_sh[CNT_W-1:0];
		end else if (cmd.sqrt_step) begin
			quot_q <= {quot_q[SUM_W-3:0], 2'b00};
			root_q <= {root_q[PCM_W-2:0], sqrt_ge};
			srem_q <= sqrt_ge ? CNT_W'(s_in - trial) : CNT_W'(s_in);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.ld_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_out) begin
			out_pcm          <= pcm_q;
			out_levels_valid <= last_q;
			out_peak         <= last_q ? peak_q : '0;
			out_rms          <= last_q ? root_q : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.last     = last_q;
	assign sts.out_free = !out_valid_q || out_ready;

	// block counter stays within one block
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(BLOCK_MAX))
		else $error("sample counter passed the block size");

	// rms of a block can never exceed its peak
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_levels_valid) |-> out_rms <= out_peak)
		else $error("rms level above peak level");

	// levels read as zero on samples that do not close a block
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_levels_valid) |-> (out_peak == '0 && out_rms == '0))
		else $error("levels reported on a non-final sample");

	// accumulators are empty right after a block closes
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ld_out && last_q) |=> (count_q == '0 && sum_q == '0 && peak_q == '0))
		else $error("block accumulators not cleared");

endmodule

// File: src/mic_gain_peak_rms_meter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mic_gain_peak_rms_meter
// Microphone gain stage with block peak and rms metering.
// ----------------------------------------------------------------------------
// Each request carries one 32-bit I2S slot; the block takes the top 18 bits,
// applies the Q10 gain (clamped to 0.1..32), truncates toward zero and
// saturates to a 16-bit sample, and returns exactly one result per request.
// Requests are handled one at a time: a plain sample passes through
// multiply, saturate, square, accumulate and output load before the next
// acceptance, and the sample marked last also runs the 47-step restoring
// divider for the mean and the 16-step square root, which share one shift
// register, before its output load. A finished result sits in an output
// register, so the next request is taken while it waits. The gain register
// is always ready and should be written only while no request is in flight.
// ----------------------------------------------------------------------------
module mic_gain_peak_rms_meter import mgprm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	mgprm_cfg_if.sink   cfg,
	mgprm_in_if.sink    in_ch,
	mgprm_out_if.source out_ch
);

	cmd_t cmd;
	sts_t sts;

	// gain writes are taken in any cycle
	assign cfg.ready = 1'b1;

	// sequencer
	mgprm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// arithmetic and output register
	mgprm_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_we           (cfg.valid),
		.cfg_gain         (cfg.gain_q10),
		.raw_slot         (in_ch.raw_slot),
		.last_in          (in_ch.last_in_block),
		.out_ready        (out_ch.ready),
		.out_valid        (out_ch.valid),
		.out_pcm          (out_ch.pcm_sample),
		.out_levels_valid (out_ch.levels_valid),
		.out_peak         (out_ch.peak_level),
		.out_rms          (out_ch.rms_level)
	);

endmodule
